// File: rtl/umx_pkg.sv
// Shared types and constants for the UM32 execute unit.
// Depends on nothing; every other file but umx_ram imports it.
package umx_pkg;

	localparam int unsigned RegCount = 8;
	localparam int unsigned RegAw = 3;
	localparam int unsigned WordW = 32;
	localparam int unsigned QueueDepth = 2;

	// Instruction and reply codes as they arrive on the opcode field.
	typedef enum logic [3:0] {
		OP_CMOV     = 4'd0,
		OP_LOAD     = 4'd1,
		OP_STORE    = 4'd2,
		OP_ADD      = 4'd3,
		OP_MUL      = 4'd4,
		OP_DIV      = 4'd5,
		OP_NAND     = 4'd6,
		OP_HALT     = 4'd7,
		OP_MAP      = 4'd8,
		OP_UNMAP    = 4'd9,
		OP_OUTPUT   = 4'd10,
		OP_INPUT    = 4'd11,
		OP_PROGLOAD = 4'd12,
		OP_LOADIMM  = 4'd13,
		OP_REPLY    = 4'd14,
		OP_ILLEGAL  = 4'd15
	} op_t;

	// Action codes of a result word.
	typedef enum logic [3:0] {
		ACT_DONE     = 4'd0,
		ACT_LOAD     = 4'd1,
		ACT_STORE    = 4'd2,
		ACT_MAP      = 4'd3,
		ACT_UNMAP    = 4'd4,
		ACT_OUTPUT   = 4'd5,
		ACT_INPUT    = 4'd6,
		ACT_PROGLOAD = 4'd7,
		ACT_HALT     = 4'd8,
		ACT_DIVZERO  = 4'd9,
		ACT_ILLEGAL  = 4'd10
	} act_t;

	// Kind of request awaiting a reply.
	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_MAP   = 2'd1,
		KIND_INPUT = 2'd2
	} kind_t;

	// Back end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDB,
		ST_RDC,
		ST_RDA,
		ST_CAP,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_RES
	} state_t;

	// One classified word as it travels through the queue.
	typedef struct packed {
		op_t               op;
		logic [RegAw-1:0]  a;
		logic [RegAw-1:0]  b;
		logic [RegAw-1:0]  c;
		logic [24:0]       imm;
		logic [WordW-1:0]  rdata;
		logic              eoi;
	} item_t;

endpackage

// File: rtl/umx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module umx_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/umx_front.sv
// Front end: takes input words into a stage register and classifies the opcode.
// Depends on umx_pkg.
module umx_front
	import umx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  opcode,
	input  logic [2:0]  dest_reg,
	input  logic [2:0]  src_reg_b,
	input  logic [2:0]  src_reg_c,
	input  logic [24:0] immediate,
	input  logic [31:0] reply_data,
	input  logic        end_of_input,
	output logic        push,
	output item_t       push_item,
	input  logic        q_full
);

	logic  valid_s1;
	item_t item_s1;
	op_t   op_dec;

	// Opcode classification; every code of the field names a member, the top one is illegal.
	assign op_dec = op_t'(opcode);

	// The stage moves on when the queue has room.
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;
	assign in_stall  = valid_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.op    <= op_dec;
			item_s1.a     <= dest_reg;
			item_s1.b     <= src_reg_b;
			item_s1.c     <= src_reg_c;
			item_s1.imm   <= immediate;
			item_s1.rdata <= reply_data;
			item_s1.eoi   <= end_of_input;
		end
	end

endmodule

// File: rtl/umx_fifo.sv
// Short queue of classified words between the front and back ends.
// Depends on umx_pkg.
module umx_fifo
	import umx_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);

	localparam int unsigned PtrW = $clog2(QueueDepth);

	item_t           buf_q [QueueDepth];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [PtrW:0]   count_q;

	assign head  = buf_q[rptr_q];
	assign full  = (count_q == (PtrW+1)'(QueueDepth));
	assign empty = (count_q == '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= push_item;
		end
	end

endmodule

// File: rtl/umx_back.sv
// Back end: sequencer, register file, multiplier, serial divider, result register.
// Depends on umx_pkg and umx_ram.
module umx_back
	import umx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       head,
	input  logic        q_empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  action,
	output logic [31:0] segment_id,
	output logic [31:0] word_offset,
	output logic [31:0] out_data,
	output logic [31:0] next_pc,
	output logic        halted
);

	state_t            state_q, state_d;
	item_t             item_q;
	logic [WordW-1:0]  ra_q, rb_q, rc_q;
	logic [WordW-1:0]  pc_q;
	logic              halt_q;
	logic              pend_q;
	logic [RegAw-1:0]  pdest_q;
	kind_t             pkind_q;
	logic [RegCount-1:0] vld_q;
	logic [RegAw-1:0]  raddr, rd_addr_q;
	logic [WordW-1:0]  ram_rdata, rd_val;
	act_t              act_q;
	logic [WordW-1:0]  seg_q, off_q, data_q;
	logic              wen_q;
	logic [RegAw-1:0]  waddr_q;
	logic [WordW-1:0]  wdata_q;
	logic [WordW-1:0]  quo_q, rem_q;
	logic [4:0]        cnt_q;
	logic [WordW:0]    div_trial;
	logic              div_bit;
	logic [WordW-1:0]  div_rem;
	logic              exec_normal;
	logic              out_load;

	// Register file: one write, one registered read; unwritten entries read zero.
	umx_ram #(
		.WIDTH(WordW),
		.DEPTH(RegCount)
	) u_regs (
		.clk  (clk),
		.we   (out_load && wen_q),
		.waddr(waddr_q),
		.wdata(wdata_q),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign rd_val = vld_q[rd_addr_q] ? ram_rdata : '0;

	// Instruction that actually runs, as opposed to a fault or a reply.
	assign exec_normal = !halt_q && item_q.op != OP_REPLY && item_q.op != OP_ILLEGAL
		&& !pend_q && !(item_q.op == OP_DIV && rc_q == '0);

	// One restoring divide step.
	assign div_trial = {rem_q, quo_q[WordW-1]};
	assign div_bit   = (div_trial >= {1'b0, rc_q});
	assign div_rem   = div_bit ? WordW'(div_trial - {1'b0, rc_q}) : div_trial[WordW-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (!q_empty) begin
				state_d = ST_RDB;
			end
			ST_RDB: state_d = ST_RDC;
			ST_RDC: state_d = ST_RDA;
			ST_RDA: state_d = ST_CAP;
			ST_CAP: state_d = ST_EXEC;
			ST_EXEC: begin
				if (exec_normal && item_q.op == OP_MUL) begin
					state_d = ST_MUL;
				end else if (exec_normal && item_q.op == OP_DIV) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_RES;
				end
			end
			ST_MUL: state_d = ST_RES;
			ST_DIV: if (cnt_q == 5'd31) begin
				state_d = ST_RES;
			end
			ST_RES: if (out_load) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: queue pop, read address, result load.
	always_comb begin
		pop      = 1'b0;
		raddr    = item_q.a;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: pop = !q_empty;
			ST_RDB:  raddr = item_q.b;
			ST_RDC:  raddr = item_q.c;
			ST_RDA:  raddr = item_q.a;
			ST_RES:  out_load = !out_valid || !out_stall;
			default: raddr = item_q.a;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= '0;
			halt_q    <= 1'b0;
			pend_q    <= 1'b0;
			pdest_q   <= '0;
			pkind_q   <= KIND_LOAD;
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (out_load && wen_q) begin
				vld_q[waddr_q] <= 1'b1;
			end
			if (state_q == ST_EXEC) begin
				if (!halt_q && item_q.op == OP_REPLY && pend_q) begin
					pend_q <= 1'b0;
				end
				if (exec_normal) begin
					pc_q <= pc_q + 1'b1;
					case (item_q.op)
						OP_HALT:     halt_q <= 1'b1;
						OP_PROGLOAD: pc_q <= rc_q;
						OP_LOAD: begin
							pend_q  <= 1'b1;
							pdest_q <= item_q.a;
							pkind_q <= KIND_LOAD;
						end
						OP_MAP: begin
							pend_q  <= 1'b1;
							pdest_q <= item_q.b;
							pkind_q <= KIND_MAP;
						end
						OP_INPUT: begin
							pend_q  <= 1'b1;
							pdest_q <= item_q.c;
							pkind_q <= KIND_INPUT;
						end
						default: ;
					endcase
				end
			end
		end
	end

	// Datapath: operand capture, execute, multiply, divide, result register.
	always_ff @(posedge clk) begin
		rd_addr_q <= raddr;
		if (pop) begin
			item_q <= head;
		end
		if (state_q == ST_RDC) begin
			rb_q <= rd_val;
		end
		if (state_q == ST_RDA) begin
			rc_q <= rd_val;
		end
		if (state_q == ST_CAP) begin
			ra_q <= rd_val;
		end
		if (state_q == ST_EXEC) begin
			act_q   <= ACT_DONE;
			seg_q   <= '0;
			off_q   <= '0;
			data_q  <= '0;
			wen_q   <= 1'b0;
			waddr_q <= item_q.a;
			wdata_q <= '0;
			quo_q   <= rb_q;
			rem_q   <= '0;
			cnt_q   <= '0;
			if (halt_q) begin
				act_q <= ACT_HALT;
			end else if (item_q.op == OP_REPLY) begin
				if (!pend_q) begin
					act_q <= ACT_ILLEGAL;
				end else begin
					wen_q   <= 1'b1;
					waddr_q <= pdest_q;
					if (pkind_q == KIND_INPUT && (item_q.eoi || item_q.rdata[31:8] != '0)) begin
						wdata_q <= '1;
					end else begin
						wdata_q <= item_q.rdata;
					end
				end
			end else if (item_q.op == OP_ILLEGAL || pend_q) begin
				act_q <= ACT_ILLEGAL;
			end else if (item_q.op == OP_DIV && rc_q == '0) begin
				act_q <= ACT_DIVZERO;
			end else begin
				case (item_q.op) inside
					OP_CMOV: begin
						wen_q   <= (rc_q != '0);
						wdata_q <= rb_q;
					end
					OP_LOAD: begin
						act_q <= ACT_LOAD;
						seg_q <= rb_q;
						off_q <= rc_q;
					end
					OP_STORE: begin
						act_q  <= ACT_STORE;
						seg_q  <= ra_q;
						off_q  <= rb_q;
						data_q <= rc_q;
					end
					OP_ADD: begin
						wen_q   <= 1'b1;
						wdata_q <= rb_q + rc_q;
					end
					OP_MUL, OP_DIV: wen_q <= 1'b1;
					OP_NAND: begin
						wen_q   <= 1'b1;
						wdata_q <= ~(rb_q & rc_q);
					end
					OP_HALT: act_q <= ACT_HALT;
					OP_MAP: begin
						act_q  <= ACT_MAP;
						data_q <= rc_q;
					end
					OP_UNMAP: begin
						act_q <= ACT_UNMAP;
						seg_q <= rc_q;
					end
					OP_OUTPUT: begin
						act_q  <= ACT_OUTPUT;
						data_q <= {24'd0, rc_q[7:0]};
					end
					OP_INPUT: act_q <= ACT_INPUT;
					OP_PROGLOAD: begin
						act_q <= ACT_PROGLOAD;
						seg_q <= rb_q;
						off_q <= rc_q;
					end
					default: begin
						wen_q   <= 1'b1;
						wdata_q <= {7'd0, item_q.imm};
					end
				endcase
			end
		end
		if (state_q == ST_MUL) begin
			wdata_q <= WordW'(rb_q * rc_q);
		end
		if (state_q == ST_DIV) begin
			rem_q <= div_rem;
			quo_q <= {quo_q[WordW-2:0], div_bit};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 5'd31) begin
				wdata_q <= {quo_q[WordW-2:0], div_bit};
			end
		end
		if (out_load) begin
			action      <= act_q;
			segment_id  <= seg_q;
			word_offset <= off_q;
			out_data    <= data_q;
			next_pc     <= pc_q;
			halted      <= halt_q;
		end
	end

`ifndef SYNTHESIS
	// Once halted, the machine stays halted.
	assert property (@(posedge clk) disable iff (!arst_n) halt_q |=> halt_q)
		else $error("halt flag cleared");
	// The divider never runs on a zero divisor.
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == ST_DIV) |-> (rc_q != '0))
		else $error("divide with zero divisor");
	// An accepted reply closes the pending request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && item_q.op == OP_REPLY && pend_q && !halt_q) |=> !pend_q)
		else $error("reply left request pending");
	// A new result is loaded only when the previous one is gone or leaving.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !out_load)
		else $error("result overwritten while stalled");
`endif

endmodule

// File: rtl/um32_execute_unit_core.sv
// Top level of the UM32 execute unit: front end, queue and back end.
// Depends on umx_pkg, umx_front, umx_fifo and umx_back.

// Each word passes through the back end in order: a pop, three reads of the
// single-read-port register file, operand capture, execute and result load.
// Multiply adds a multiply step and divide adds the bit-serial divider. The front
// end and a two-entry queue accept further words while the back end works, and a
// finished result waits in the output register.
module um32_execute_unit_core
	import umx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  opcode,
	input  logic [2:0]  dest_reg,
	input  logic [2:0]  src_reg_b,
	input  logic [2:0]  src_reg_c,
	input  logic [24:0] immediate,
	input  logic [31:0] reply_data,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  action,
	output logic [31:0] segment_id,
	output logic [31:0] word_offset,
	output logic [31:0] out_data,
	output logic [31:0] next_pc,
	output logic        halted
);

	logic  push, pop, q_full, q_empty;
	item_t push_item, head;

	umx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.dest_reg    (dest_reg),
		.src_reg_b   (src_reg_b),
		.src_reg_c   (src_reg_c),
		.immediate   (immediate),
		.reply_data  (reply_data),
		.end_of_input(end_of_input),
		.push        (push),
		.push_item   (push_item),
		.q_full      (q_full)
	);

	umx_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	umx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action),
		.segment_id (segment_id),
		.word_offset(word_offset),
		.out_data   (out_data),
		.next_pc    (next_pc),
		.halted     (halted)
	);

endmodule

// File: verif/testbench.sv
// Testbench for the UM32 execute unit: random and directed instruction streams
// checked against a behavioural model of the register file, pc and halt flag.
// Depends on umx_pkg and um32_execute_unit_core.
module testbench;
	import umx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		op_t         op;
		logic [2:0]  a, b, c;
		logic [24:0] imm;
		logic [31:0] rdata;
		logic        eoi;
	} instr_t;

	typedef struct {
		act_t        act;
		logic [31:0] seg, off, data, pc;
		logic        halt;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] opcode = '0;
	logic [2:0] dest_reg = '0, src_reg_b = '0, src_reg_c = '0;
	logic [24:0] immediate = '0;
	logic [31:0] reply_data = '0;
	logic end_of_input = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] action;
	logic [31:0] segment_id, word_offset, out_data, next_pc;
	logic halted;
	logic in_fire = 1'b0;

	instr_t   pending_words[$];
	outcome_t expected_outcomes[$];
	int       error_count = 0;
	int       cycle_count = 0;
	int       idle_left = 0;
	int       stall_left = 0;
	bit       stimulus_done = 1'b0;

	// Model state of the machine.
	logic [31:0] regs[8];
	logic [31:0] pc;
	logic        model_stopped;
	logic [2:0]  wait_dest;
	logic        wait_open;
	kind_t       wait_kind;

	um32_execute_unit_core dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one, sometimes none at all.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Work out the result of one word and update the model state.
	function automatic outcome_t execute_word(instr_t w);
		outcome_t o;
		logic [31:0] ra, rb, rc;
		ra = regs[w.a];
		rb = regs[w.b];
		rc = regs[w.c];
		o.act = ACT_DONE;
		o.seg = '0;
		o.off = '0;
		o.data = '0;
		if (model_stopped) begin
			o.act = ACT_HALT;
		end else if (w.op == OP_REPLY) begin
			if (!wait_open) begin
				o.act = ACT_ILLEGAL;
			end else begin
				if (wait_kind == KIND_INPUT && (w.eoi || w.rdata > 32'd255))
					regs[wait_dest] = '1;
				else
					regs[wait_dest] = w.rdata;
				wait_open = 1'b0;
			end
		end else if (w.op == OP_ILLEGAL || wait_open) begin
			o.act = ACT_ILLEGAL;
		end else if (w.op == OP_DIV && rc == 0) begin
			o.act = ACT_DIVZERO;
		end else begin
			pc = pc + 1;
			case (w.op)
				OP_CMOV: if (rc != 0) regs[w.a] = rb;
				OP_LOAD: begin
					o.act = ACT_LOAD; o.seg = rb; o.off = rc;
					wait_dest = w.a; wait_kind = KIND_LOAD; wait_open = 1'b1;
				end
				OP_STORE: begin
					o.act = ACT_STORE; o.seg = ra; o.off = rb; o.data = rc;
				end
				OP_ADD: regs[w.a] = rb + rc;
				OP_MUL: regs[w.a] = rb * rc;
				OP_DIV: regs[w.a] = rb / rc;
				OP_NAND: regs[w.a] = ~(rb & rc);
				OP_HALT: begin
					o.act = ACT_HALT; model_stopped = 1'b1;
				end
				OP_MAP: begin
					o.act = ACT_MAP; o.data = rc;
					wait_dest = w.b; wait_kind = KIND_MAP; wait_open = 1'b1;
				end
				OP_UNMAP: begin
					o.act = ACT_UNMAP; o.seg = rc;
				end
				OP_OUTPUT: begin
					o.act = ACT_OUTPUT; o.data = {24'd0, rc[7:0]};
				end
				OP_INPUT: begin
					o.act = ACT_INPUT;
					wait_dest = w.c; wait_kind = KIND_INPUT; wait_open = 1'b1;
				end
				OP_PROGLOAD: begin
					o.act = ACT_PROGLOAD; o.seg = rb; o.off = rc; pc = rc;
				end
				default: regs[w.a] = {7'd0, w.imm};
			endcase
		end
		o.pc = pc;
		o.halt = model_stopped;
		return o;
	endfunction

	function automatic instr_t make_word(op_t op, int a, int b, int c,
			logic [24:0] imm, logic [31:0] rdata, int eoi);
		instr_t w;
		w.op = op; w.a = 3'(a); w.b = 3'(b); w.c = 3'(c);
		w.imm = imm; w.rdata = rdata; w.eoi = 1'(eoi);
		return w;
	endfunction

	// Random word; replies are mostly answered so that sequences run deep.
	function automatic instr_t random_word(bit reply_due);
		instr_t w;
		int r;
		w.a = 3'($urandom); w.b = 3'($urandom); w.c = 3'($urandom);
		w.imm = 25'($urandom);
		r = $urandom_range(0, 9);
		w.rdata = (r < 4) ? $urandom_range(0, 300) : (r < 6 ? 32'hFFFF_FFFF : $urandom);
		w.eoi = ($urandom_range(0, 4) == 0);
		if (reply_due && $urandom_range(0, 19) != 0) begin
			w.op = OP_REPLY;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 20) w.op = OP_LOADIMM;
			else if (r < 22) w.op = OP_ILLEGAL;
			else if (r < 24) w.op = OP_REPLY;
			else if (r < 25) w.op = OP_PROGLOAD;
			else begin
				w.op = op_t'($urandom_range(0, 11));
				if (w.op == OP_HALT) w.op = OP_ADD;
			end
		end
		return w;
	endfunction

	// Driver: present queued words at the falling edge, holding while stalled.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					instr_t w;
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					opcode <= w.op; dest_reg <= w.a; src_reg_b <= w.b; src_reg_c <= w.c;
					immediate <= w.imm; reply_data <= w.rdata; end_of_input <= w.eoi;
					expected_outcomes.push_back(execute_word(w));
					idle_left = gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
			// Result side back-pressure in runs of random length.
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = gap_len();
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			outcome_t e;
			if (expected_outcomes.size() == 0) begin
				$error("unexpected result word, action %0d", action);
				error_count++;
			end else begin
				e = expected_outcomes.pop_front();
				if (action !== e.act) begin
					$error("action: expected %0d, got %0d", e.act, action);
					error_count++;
				end
				if (segment_id !== e.seg) begin
					$error("segment_id: expected %h, got %h", e.seg, segment_id);
					error_count++;
				end
				if (word_offset !== e.off) begin
					$error("word_offset: expected %h, got %h", e.off, word_offset);
					error_count++;
				end
				if (out_data !== e.data) begin
					$error("out_data: expected %h, got %h", e.data, out_data);
					error_count++;
				end
				if (next_pc !== e.pc) begin
					$error("next_pc: expected %h, got %h", e.pc, next_pc);
					error_count++;
				end
				if (halted !== e.halt) begin
					$error("halted: expected %b, got %b", e.halt, halted);
					error_count++;
				end
			end
		end
	end

	// Stimulus: directed words first, then random programs, one halt at the end.
	initial begin
		bit reply_due;
		int n;
		instr_t w;
		for (int i = 0; i < 8; i++) regs[i] = '0;
		pc = '0; model_stopped = 1'b0; wait_dest = '0; wait_open = 1'b0; wait_kind = KIND_LOAD;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Extremes of the fields, every operation but halt and each corner.
		pending_words.push_back(make_word(OP_REPLY, 0, 0, 0, '0, '0, 0));
		pending_words.push_back(make_word(OP_LOADIMM, 1, 0, 0, 25'h1FF_FFFF, '0, 0));
		pending_words.push_back(make_word(OP_LOADIMM, 7, 7, 7, '0, '1, 1));
		pending_words.push_back(make_word(OP_NAND, 2, 7, 7, '0, '0, 0));
		pending_words.push_back(make_word(OP_DIV, 3, 1, 7, '0, '0, 0));
		pending_words.push_back(make_word(OP_MUL, 3, 2, 2, '0, '0, 0));
		pending_words.push_back(make_word(OP_ADD, 4, 2, 1, '0, '0, 0));
		pending_words.push_back(make_word(OP_DIV, 5, 2, 1, '0, '0, 0));
		pending_words.push_back(make_word(OP_CMOV, 6, 2, 7, '0, '0, 0));
		pending_words.push_back(make_word(OP_CMOV, 6, 1, 2, '0, '0, 0));
		pending_words.push_back(make_word(OP_STORE, 2, 1, 4, '0, '0, 0));
		pending_words.push_back(make_word(OP_LOAD, 5, 2, 1, '0, '0, 0));
		pending_words.push_back(make_word(OP_ADD, 0, 0, 0, '0, '0, 0));
		pending_words.push_back(make_word(OP_REPLY, 0, 0, 0, '0, 32'hFFFF_FFFF, 1));
		pending_words.push_back(make_word(OP_MAP, 0, 3, 1, '0, '0, 0));
		pending_words.push_back(make_word(OP_REPLY, 0, 0, 0, '0, 32'h1234_5678, 1));
		pending_words.push_back(make_word(OP_INPUT, 0, 0, 6, '0, '0, 0));
		pending_words.push_back(make_word(OP_REPLY, 0, 0, 0, '0, 32'd255, 0));
		pending_words.push_back(make_word(OP_INPUT, 0, 0, 5, '0, '0, 0));
		pending_words.push_back(make_word(OP_REPLY, 0, 0, 0, '0, 32'd256, 0));
		pending_words.push_back(make_word(OP_INPUT, 0, 0, 4, '0, '0, 0));
		pending_words.push_back(make_word(OP_REPLY, 0, 0, 0, '0, 32'd7, 1));
		pending_words.push_back(make_word(OP_OUTPUT, 0, 0, 2, '0, '0, 0));
		pending_words.push_back(make_word(OP_UNMAP, 0, 0, 1, '0, '0, 0));
		pending_words.push_back(make_word(OP_PROGLOAD, 0, 0, 2, '0, '0, 0));
		pending_words.push_back(make_word(OP_ILLEGAL, 0, 0, 0, '0, '0, 0));

		// Random programs; a shadow of the pending flag steers replies.
		reply_due = 1'b0;
		n = 0;
		while (n < 1530) begin
			w = random_word(reply_due);
			if (w.op == OP_REPLY) reply_due = 1'b0;
			else if (!reply_due && (w.op == OP_LOAD || w.op == OP_MAP || w.op == OP_INPUT))
				reply_due = 1'b1;
			pending_words.push_back(w);
			n++;
			if (n % 8 == 0) repeat (gap_len()) @(negedge clk);
		end
		// Halt, then a few ignored words.
		if (reply_due) pending_words.push_back(make_word(OP_REPLY, 0, 0, 0, '0, 32'd9, 0));
		pending_words.push_back(make_word(OP_HALT, 0, 0, 0, '0, '0, 0));
		pending_words.push_back(make_word(OP_ADD, 1, 2, 3, '0, '0, 0));
		pending_words.push_back(make_word(OP_REPLY, 1, 2, 3, '0, '0, 1));
		stimulus_done = 1'b1;
	end

	// End of run: drain, settle, then report.
	initial begin
		wait (stimulus_done);
		wait (pending_words.size() == 0 && !in_valid && expected_outcomes.size() == 0);
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_outcomes.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (cycle_count == 2000000) begin
			$display("testbench: errors");
			$finish;
		end
	end
endmodule
